### sv/cdq_pkg.sv
// ----------------------------------------------------------------------------
// Circular deque package
// Operation and status codes and the word types shared by the deque blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

  // Operation codes carried in the kind field of an input word.
  localparam logic [1:0] KIND_PUSH_BACK  = 2'd0;
  localparam logic [1:0] KIND_PUSH_FRONT = 2'd1;
  localparam logic [1:0] KIND_POP_BACK   = 2'd2;
  localparam logic [1:0] KIND_POP_FRONT  = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // Input word.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] item_value;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [31:0] popped_value;
    logic [1:0]  status;
    logic [7:0]  occupancy;
  } out_word_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_LOAD
  } cdq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load;
  } cdq_cmd_t;

endpackage : cdq_pkg

`default_nettype wire

### sv/circular_double_ended_queue.sv
// ----------------------------------------------------------------------------
// Circular double-ended queue
// Fixed-capacity deque in a ring store with push and pop at both ends.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready, in_data) takes one word per
//   operation: push back, push front, pop back or pop front. Every word
//   yields exactly one result word on the output channel (out_valid,
//   out_ready, out_data) with the popped value, a status and the occupancy.
//   A push to a full queue or a pop from an empty one changes nothing and
//   reports full or empty status with a zero value.
//   out_valid rises when the output register loads the result. The
//   controller handles one word at a time: the store is read at the
//   accepting edge, and the output register loads from the load state once
//   it is free, so no new word is taken until that result has been loaded.
//   The next word is accepted while a result still waits in the output
//   register; if the receiver stalls, that following result waits in the
//   controller and in_ready stays low until the output register frees.
//   Reset clears the indices, the count and the output valid flag; the
//   store contents are not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module circular_double_ended_queue
  import cdq_pkg::*;
#(
  parameter int CAPACITY    = 128,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_word_t     out_data
);

  cdq_cmd_t cmd;

  // Operation sequencer.
  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Store, indices and result register.
  cdq_dpath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

`ifndef ASSERT_OFF
  // One word at a time: after an accept the input side closes.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a word was in progress");

  // A rejected operation never returns a value.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != STATUS_DONE) |-> (out_data.popped_value == '0))
    else $error("rejected operation returned a nonzero value");

  // Status is always one of the defined codes.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == STATUS_DONE || out_data.status == STATUS_FULL ||
                   out_data.status == STATUS_EMPTY))
    else $error("undefined status code on output");

  // A full status is only reported with the queue at capacity.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == STATUS_FULL) |-> (out_data.occupancy == 8'(CAPACITY)))
    else $error("full status with occupancy below capacity");
`endif

endmodule : circular_double_ended_queue

`default_nettype wire

### sv/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// Circular deque controller
// Sequences one operation at a time: accept a word, then load its result
// into the output register once that register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdq_ctrl
  import cdq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output cdq_cmd_t      cmd
);

  cdq_state_t state;
  cdq_state_t state_next;
  logic       out_valid_next;
  logic       out_free;

  // The output register can take a new result when it is empty or being read.
  assign out_free = !out_valid || out_ready;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !rst) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = !rst;
        cmd.accept = in_valid && !rst;
      end
      ST_LOAD: begin
        cmd.load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Output valid flag follows loads and consumer reads.
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule : cdq_ctrl

`default_nettype wire

### sv/cdq_dpath.sv
// ----------------------------------------------------------------------------
// Circular deque datapath
// Ring store, front and back indices, entry count and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdq_dpath
  import cdq_pkg::*;
#(
  parameter int CAPACITY    = 128,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cdq_cmd_t cmd,
  input  wire in_word_t in_data,
  output out_word_t     out_data
);

  // Stored width: items arrive as 32-bit words, so no more is kept.
  localparam int SW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST_INDEX = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  logic [SW-1:0] ring_store [CAPACITY];
  logic [SW-1:0] rdata;

  logic [IW-1:0] front_index;
  logic [IW-1:0] back_index;
  logic [CW-1:0] entry_count;
  logic [IW-1:0] front_index_next;
  logic [IW-1:0] back_index_next;
  logic [CW-1:0] entry_count_next;

  logic [IW-1:0] front_inc;
  logic [IW-1:0] front_dec;
  logic [IW-1:0] back_inc;
  logic [IW-1:0] back_dec;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [1:0]    status_next;

  logic          pend_pop;
  logic [1:0]    pend_status;
  logic [7:0]    pend_occ;

  // Wrapping index neighbors.
  assign front_inc = (front_index == LAST_INDEX) ? '0 : front_index + 1'b1;
  assign front_dec = (front_index == '0) ? LAST_INDEX : front_index - 1'b1;
  assign back_inc  = (back_index == LAST_INDEX) ? '0 : back_index + 1'b1;
  assign back_dec  = (back_index == '0) ? LAST_INDEX : back_index - 1'b1;

  // Decode the operation against the current occupancy.
  always_comb begin
    front_index_next = front_index;
    back_index_next  = back_index;
    entry_count_next = entry_count;
    wr_en            = 1'b0;
    wr_addr          = back_index;
    rd_en            = 1'b0;
    rd_addr          = front_index;
    status_next      = STATUS_DONE;
    unique case (in_data.kind)
      KIND_PUSH_BACK: begin
        if (entry_count == FULL_COUNT) begin
          status_next = STATUS_FULL;
        end else begin
          wr_en            = cmd.accept;
          wr_addr          = back_index;
          back_index_next  = back_inc;
          entry_count_next = entry_count + 1'b1;
        end
      end
      KIND_PUSH_FRONT: begin
        if (entry_count == FULL_COUNT) begin
          status_next = STATUS_FULL;
        end else begin
          wr_en            = cmd.accept;
          wr_addr          = front_dec;
          front_index_next = front_dec;
          entry_count_next = entry_count + 1'b1;
        end
      end
      KIND_POP_BACK: begin
        if (entry_count == '0) begin
          status_next = STATUS_EMPTY;
        end else begin
          rd_en            = cmd.accept;
          rd_addr          = back_dec;
          back_index_next  = back_dec;
          entry_count_next = entry_count - 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (entry_count == '0) begin
          status_next = STATUS_EMPTY;
        end else begin
          rd_en            = cmd.accept;
          rd_addr          = front_index;
          front_index_next = front_inc;
          entry_count_next = entry_count - 1'b1;
        end
      end
      default: status_next = STATUS_DONE;
    endcase
  end

  // Ring store with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_store[wr_addr] <= SW'(in_data.item_value);
    end
    if (rd_en) begin
      rdata <= ring_store[rd_addr];
    end
  end

  // Indices and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      back_index  <= '0;
      entry_count <= '0;
    end else if (cmd.accept) begin
      front_index <= front_index_next;
      back_index  <= back_index_next;
      entry_count <= entry_count_next;
    end
  end

  // Result fields held until the output register takes them.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_pop    <= rd_en;
      pend_status <= status_next;
      pend_occ    <= 8'(entry_count_next);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data.popped_value <= pend_pop ? 32'(rdata) : '0;
      out_data.status       <= pend_status;
      out_data.occupancy    <= pend_occ;
    end
  end

endmodule : cdq_dpath

`default_nettype wire
